// ----- rtl/utc_pkg.sv -----
package utc_pkg;

  localparam int unsigned UnitWidth  = 16;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned AccWidth   = 31;
  localparam int unsigned MaxBytes   = 4;
  localparam int unsigned CountWidth = 3;

  // Register indexes on the configuration port.
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_SWAP      = 1'b1;

  // Conversion directions.
  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  localparam logic [7:0] CONT_MARK    = 8'h80;
  localparam logic [7:0] CONT_MASK    = 8'h3F;
  localparam logic [7:0] LEAD2_MARK   = 8'hC0;
  localparam logic [7:0] LEAD3_MARK   = 8'hE0;
  localparam logic [7:0] LEAD_MASK    = 8'h7F;
  localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;

  typedef logic [ByteWidth-1:0] byte_t;

  // Bytes produced by one word; entry 0 leaves first.
  typedef struct packed {
    logic [CountWidth-1:0]          cnt;
    logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
    logic                           eos;
    logic                           pd;
  } result_t;

endpackage

// ----- rtl/utc_in_if.sv -----
interface utc_in_if;
  logic                            valid;
  logic                            ready;
  logic [utc_pkg::UnitWidth-1:0]   in_value;

  modport source (output valid, output in_value, input ready);
  modport sink   (input valid, input in_value, output ready);
endinterface

// ----- rtl/utc_out_if.sv -----
interface utc_out_if;
  logic                          valid;
  logic                          ready;
  logic [utc_pkg::ByteWidth-1:0] out_byte;
  logic                          last_of_run;
  logic                          end_of_string;
  logic                          partial_dropped;

  modport source (output valid, output out_byte, output last_of_run,
                  output end_of_string, output partial_dropped, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input end_of_string, input partial_dropped, output ready);
endinterface

// ----- rtl/utf8_ucs_transcoder_core.sv -----
// Channel   Dir  Word                       Notes
// stream    in   in_value[15:0]             UTF-8 byte in [7:0] or 16-bit code unit
// result    out  out_byte, flags            one output byte per transfer
// apb       cfg  direction, swap_unit_bytes registers at 0x0 and 0x4
//
// A word is taken into an input register, converted combinationally into a
// result buffer of up to four bytes, and the buffer drains one byte per cycle
// while the result side is ready. The input register holds the next word while
// the buffer drains, and the buffer reloads as its last byte is taken; the single
// output byte port limits the sustained rate. rst is synchronous and clears the
// sequence state, the registers and all valid flags. Both sides may stall freely.
module utf8_ucs_transcoder_core (
  input  logic         clk,
  input  logic         rst,
  utc_in_if.sink       stream,
  utc_out_if.source    result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic direction;
  logic swap_unit_bytes;

  logic                                hold_valid;
  logic [utc_pkg::UnitWidth-1:0]       hold_value;
  logic                                hold_move;

  logic [2:0]                          seq_len, seq_len_next;
  logic [2:0]                          rem, rem_next;
  logic [utc_pkg::AccWidth-1:0]        acc, acc_next;

  logic [utc_pkg::CountWidth-1:0]      buf_cnt;
  logic [utc_pkg::MaxBytes-1:0][utc_pkg::ByteWidth-1:0] buf_bytes;
  logic                                buf_eos;
  logic                                buf_pd;
  logic                                buf_free;
  logic                                take;

  utc_pkg::result_t res;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction       <= utc_pkg::DIR_DECODE;
      swap_unit_bytes <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        utc_pkg::REG_DIRECTION: direction       <= pwdata[0];
        utc_pkg::REG_SWAP:      swap_unit_bytes <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      utc_pkg::REG_DIRECTION: prdata[0] = direction;
      utc_pkg::REG_SWAP:      prdata[0] = swap_unit_bytes;
      default: ;
    endcase
  end

  // Handshakes.
  assign take      = result.valid && result.ready;
  assign buf_free  = (buf_cnt == '0) || (take && buf_cnt == 3'd1);
  assign hold_move = hold_valid && buf_free;
  assign stream.ready = !hold_valid || buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (stream.ready) begin
      hold_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      hold_value <= stream.in_value;
    end
  end

  function automatic logic [1:0][7:0] order_half(input logic [15:0] half, input logic swap);
    logic [1:0][7:0] r;
    if (swap) begin
      r[0] = half[7:0];
      r[1] = half[15:8];
    end else begin
      r[0] = half[15:8];
      r[1] = half[7:0];
    end
    return r;
  endfunction

  // Conversion of the held word.
  always_comb begin
    logic [15:0]                    v;
    logic [7:0]                     b;
    logic [2:0]                     n;
    logic                           drop;
    logic [utc_pkg::AccWidth-1:0]   acc_shift;

    res          = '0;
    seq_len_next = seq_len;
    rem_next     = rem;
    acc_next     = acc;
    v = (direction == utc_pkg::DIR_DECODE) ? {8'h00, hold_value[7:0]} : hold_value;
    b = hold_value[7:0];
    acc_shift = {acc[utc_pkg::AccWidth-7:0], b[5:0]};

    // Leading ones of the byte; drop marks 0xFE and 0xFF.
    drop = 1'b0;
    priority if (!b[7]) n = 3'd0;
    else if (!b[6])     n = 3'd1;
    else if (!b[5])     n = 3'd2;
    else if (!b[4])     n = 3'd3;
    else if (!b[3])     n = 3'd4;
    else if (!b[2])     n = 3'd5;
    else if (!b[1])     n = 3'd6;
    else begin
      n    = 3'd7;
      drop = 1'b1;
    end

    if (v == '0) begin
      res.eos      = 1'b1;
      res.pd       = (rem != '0);
      res.cnt      = (direction == utc_pkg::DIR_DECODE) ? 3'd2 : 3'd1;
      seq_len_next = '0;
      rem_next     = '0;
      acc_next     = '0;
    end else if (direction == utc_pkg::DIR_DECODE) begin
      if (n == 3'd0) begin
        seq_len_next   = '0;
        rem_next       = '0;
        acc_next       = '0;
        res.bytes[1:0] = order_half({8'h00, b}, swap_unit_bytes);
        res.cnt        = 3'd2;
      end else if (n == 3'd1) begin
        // Continuation bytes with no open sequence are ignored.
        if (rem != '0) begin
          acc_next = acc_shift;
          rem_next = rem - 3'd1;
          if (rem == 3'd1) begin
            if (seq_len <= 3'd3) begin
              res.bytes[1:0] = order_half(acc_shift[15:0], swap_unit_bytes);
              res.cnt        = 3'd2;
            end else begin
              res.bytes[1:0] = order_half({1'b0, acc_shift[30:16]}, swap_unit_bytes);
              res.bytes[3:2] = order_half(acc_shift[15:0], swap_unit_bytes);
              res.cnt        = 3'd4;
            end
            seq_len_next = '0;
            acc_next     = '0;
          end
        end
      end else if (!drop) begin
        seq_len_next = n;
        rem_next     = n - 3'd1;
        acc_next     = {23'd0, b & (utc_pkg::LEAD_MASK >> n)};
      end
    end else begin
      if (v <= utc_pkg::ONE_BYTE_MAX) begin
        res.bytes[0] = v[7:0];
        res.cnt      = 3'd1;
      end else if (v <= utc_pkg::TWO_BYTE_MAX) begin
        res.bytes[0] = utc_pkg::LEAD2_MARK | {3'b000, v[10:6]};
        res.bytes[1] = utc_pkg::CONT_MARK | (v[7:0] & utc_pkg::CONT_MASK);
        res.cnt      = 3'd2;
      end else begin
        res.bytes[0] = utc_pkg::LEAD3_MARK | {4'h0, v[15:12]};
        res.bytes[1] = utc_pkg::CONT_MARK | {2'b00, v[11:6]};
        res.bytes[2] = utc_pkg::CONT_MARK | (v[7:0] & utc_pkg::CONT_MASK);
        res.cnt      = 3'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= '0;
      rem     <= '0;
      acc     <= '0;
    end else if (hold_move) begin
      seq_len <= seq_len_next;
      rem     <= rem_next;
      acc     <= acc_next;
    end
  end

  // Result buffer; bytes shift towards entry 0 as they are taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
    end else if (hold_move) begin
      buf_cnt <= res.cnt;
    end else if (take) begin
      buf_cnt <= buf_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_move) begin
      buf_bytes <= res.bytes;
      buf_eos   <= res.eos;
      buf_pd    <= res.pd;
    end else if (take) begin
      buf_bytes <= {8'h00, buf_bytes[3:1]};
    end
  end

  assign result.valid           = (buf_cnt != '0);
  assign result.out_byte        = buf_bytes[0];
  assign result.last_of_run     = (buf_cnt == 3'd1);
  assign result.end_of_string   = buf_eos;
  assign result.partial_dropped = buf_pd;

endmodule

// ----- rtl/utc_checker.sv -----
module utc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       end_of_string,
  input logic       partial_dropped
);

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

  a_word_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(last_of_run)
                                && $stable(end_of_string) && $stable(partial_dropped))
    else $error("result word changed while stalled");

  // Terminator bytes are always zero.
  a_eos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_string |-> out_byte == 8'h00)
    else $error("terminator byte is not zero");

  a_pd_on_eos: assert property (@(posedge clk) disable iff (rst)
    out_valid && partial_dropped |-> end_of_string)
    else $error("abandoned sequence flagged outside a terminator");

endmodule

bind utf8_ucs_transcoder_core utc_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_byte        (result.out_byte),
  .last_of_run     (result.last_of_run),
  .end_of_string   (result.end_of_string),
  .partial_dropped (result.partial_dropped)
);
